>>> src/mi3_pkg.sv
// Shared types, widths and constants for the 3x3 matrix inverse block.
package mi3_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Full-width intermediates: cofactor, determinant, scaled numerator
  localparam int ADJ_W  = 2 * DATA_WIDTH + 1;
  localparam int DET_W  = 3 * DATA_WIDTH + 3;
  localparam int NUM_W  = ADJ_W + 2 * FRAC_BITS;
  localparam int CMP_W  = ((DET_W + DATA_WIDTH > NUM_W) ? DET_W + DATA_WIDTH : NUM_W) + 1;

  // Front end stages, divider lane stages, merge register
  localparam int FRONT_LAT = 6;
  localparam int LANE_LAT  = DATA_WIDTH + 2;
  localparam int LATENCY   = FRONT_LAT + LANE_LAT + 1;

  localparam int NUM_ENTRIES = 9;

  // Cofactor operand indexes: adj = e[a]*e[b] - e[c]*e[d]
  localparam logic [3:0] COF_IDX [NUM_ENTRIES][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Cofactors of row 0 used in the determinant expansion
  localparam logic [3:0] DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r00;
    logic signed [DATA_WIDTH-1:0] r01;
    logic signed [DATA_WIDTH-1:0] r02;
    logic signed [DATA_WIDTH-1:0] r10;
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r20;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    logic                         singular;
    logic                         saturated;
  } out_word_t;

endpackage

>>> src/mi3_front.sv
// Cofactor and determinant pipeline: forms magnitudes and signs for the divider lanes.
module mi3_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  mi3_pkg::in_word_t                   in_word,
  output logic                                f_valid,
  output logic                                f_singular,
  output logic [mi3_pkg::DET_W-1:0]           f_den,
  output logic [mi3_pkg::NUM_W-1:0]           f_num [mi3_pkg::NUM_ENTRIES],
  output logic                                f_neg [mi3_pkg::NUM_ENTRIES]
);
  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;

  logic signed [W-1:0]       e         [NUM_ENTRIES];
  logic signed [2*W-1:0]     pa_r      [NUM_ENTRIES];
  logic signed [2*W-1:0]     pb_r      [NUM_ENTRIES];
  logic signed [W-1:0]       row0_a_r  [3];
  logic signed [W-1:0]       row0_b_r  [3];
  logic signed [ADJ_W-1:0]   adj_b_r   [NUM_ENTRIES];
  logic signed [ADJ_W-1:0]   adj_c_r   [NUM_ENTRIES];
  logic signed [ADJ_W-1:0]   adj_d_r   [NUM_ENTRIES];
  logic signed [ADJ_W-1:0]   adj_e_r   [NUM_ENTRIES];
  logic signed [2*W:0]       plo_r     [3];
  logic signed [2*W:0]       phi_r     [3];
  logic signed [DET_W-1:0]   term_r    [3];
  logic signed [DET_W-1:0]   det_r;
  logic [ADJ_W-1:0]          adj_mag   [NUM_ENTRIES];
  logic [DET_W-1:0]          det_mag;
  logic [DET_W-1:0]          den_r;
  logic                      sing_r;
  logic [NUM_W-1:0]          num_r     [NUM_ENTRIES];
  logic                      neg_r     [NUM_ENTRIES];
  logic [FRONT_LAT-1:0]      vld_r;
  logic [FRONT_LAT-1:0]      vld_nxt;

  // Unpack the input word into row-major entries
  assign e[0] = in_word.m00;
  assign e[1] = in_word.m01;
  assign e[2] = in_word.m02;
  assign e[3] = in_word.m10;
  assign e[4] = in_word.m11;
  assign e[5] = in_word.m12;
  assign e[6] = in_word.m20;
  assign e[7] = in_word.m21;
  assign e[8] = in_word.m22;

  // Advance the valid marker through the front stages
  assign vld_nxt = {vld_r[FRONT_LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Take magnitudes of the cofactors and of the determinant
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      adj_mag[i] = adj_e_r[i][ADJ_W-1] ? ADJ_W'(-adj_e_r[i]) : ADJ_W'(adj_e_r[i]);
    end
    det_mag = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
  end

  // Pipeline stages A..F
  always_ff @(posedge clk) begin
    // A: cofactor products
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      pa_r[i] <= e[COF_IDX[i][0]] * e[COF_IDX[i][1]];
      pb_r[i] <= e[COF_IDX[i][2]] * e[COF_IDX[i][3]];
    end
    for (int j = 0; j < 3; j++) begin
      row0_a_r[j] <= e[j];
    end
    // B: cofactors
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      adj_b_r[i] <= {pa_r[i][2*W-1], pa_r[i]} - {pb_r[i][2*W-1], pb_r[i]};
    end
    row0_b_r <= row0_a_r;
    // C: split partial products of the row-0 expansion
    for (int j = 0; j < 3; j++) begin
      plo_r[j] <= row0_b_r[j] * $signed({1'b0, adj_b_r[DET_COF[j]][W-1:0]});
      phi_r[j] <= row0_b_r[j] * $signed(adj_b_r[DET_COF[j]][ADJ_W-1:W]);
    end
    adj_c_r <= adj_b_r;
    // D: recombine partial products
    for (int j = 0; j < 3; j++) begin
      term_r[j] <= (DET_W'(phi_r[j]) << W) + DET_W'(plo_r[j]);
    end
    adj_d_r <= adj_c_r;
    // E: determinant
    det_r   <= term_r[0] + term_r[1] + term_r[2];
    adj_e_r <= adj_d_r;
    // F: magnitudes, scaled numerators and quotient signs
    den_r  <= det_mag;
    sing_r <= (det_r == '0);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      num_r[i] <= NUM_W'(adj_mag[i]) << (2 * FRAC_BITS);
      neg_r[i] <= adj_e_r[i][ADJ_W-1] ^ det_r[DET_W-1];
    end
  end

  assign f_valid    = vld_r[FRONT_LAT-1];
  assign f_singular = sing_r;
  assign f_den      = den_r;
  assign f_num      = num_r;
  assign f_neg      = neg_r;

endmodule

>>> src/mi3_div_lane.sv
// One divider lane: restoring quotient, one bit per stage, then saturate and sign.
module mi3_div_lane (
  input  logic                                 clk,
  input  logic [mi3_pkg::NUM_W-1:0]            num,
  input  logic [mi3_pkg::DET_W-1:0]            den,
  input  logic                                 neg,
  output logic signed [mi3_pkg::DATA_WIDTH-1:0] res,
  output logic                                 sat
);
  import mi3_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [CMP_W-1:0] rem_r  [W+1];
  logic [DET_W-1:0] den_r  [W+1];
  logic [W-1:0]     q_r    [W+1];
  logic             neg_r  [W+1];
  logic             big_r  [W+1];
  logic [CMP_W-1:0] trial  [W];
  logic             ge     [W];
  logic [W-1:0]     lim;
  logic [W-1:0]     val;
  logic             sat_nxt;
  logic signed [W-1:0] res_r;
  logic             sat_r;

  // Compare against the divisor shifted to each quotient bit
  always_comb begin
    for (int s = 0; s < W; s++) begin
      trial[s] = CMP_W'(den_r[s]) << (W - 1 - s);
      ge[s]    = (rem_r[s] >= trial[s]);
    end
  end

  // Clip to the signed range and apply the sign
  always_comb begin
    lim     = neg_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat_nxt = big_r[W] || (q_r[W] > lim);
    val     = sat_nxt ? lim : q_r[W];
  end

  always_ff @(posedge clk) begin
    // Entry: flag quotients too large for the quotient register
    rem_r[0] <= CMP_W'(num);
    den_r[0] <= den;
    q_r[0]   <= '0;
    neg_r[0] <= neg;
    big_r[0] <= (CMP_W'(num) >= (CMP_W'(den) << W));
    // Quotient bits, most significant first
    for (int s = 0; s < W; s++) begin
      rem_r[s+1] <= ge[s] ? rem_r[s] - trial[s] : rem_r[s];
      q_r[s+1]   <= {q_r[s][W-2:0], ge[s]};
      den_r[s+1] <= den_r[s];
      neg_r[s+1] <= neg_r[s];
      big_r[s+1] <= big_r[s];
    end
    res_r <= neg_r[W] ? W'(-val) : val;
    sat_r <= sat_nxt;
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

>>> src/matrix_inverse_3x3_top.sv
// Top level of the 3x3 matrix inverse: front end, nine divider lanes, merge register.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------
//   input    | start, busy          | in_word  (m00..m22, Q16.16)
//   result   | out_strobe           | out_word (r00..r22, singular, saturated)
//
// One matrix is taken every cycle; busy stays low.
// Each result passes through six front stages, DATA_WIDTH + 2 lane stages (entry, one per
// quotient bit, sign) and the merge register before it is strobed.
// Reset clears only the valid markers; words in flight are dropped.
// The result is shown for one cycle and cannot be held off.
module matrix_inverse_3x3_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mi3_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output mi3_pkg::out_word_t out_word
);
  import mi3_pkg::*;

  logic             f_valid;
  logic             f_singular;
  logic [DET_W-1:0] f_den;
  logic [NUM_W-1:0] f_num [NUM_ENTRIES];
  logic             f_neg [NUM_ENTRIES];
  logic signed [DATA_WIDTH-1:0] lane_res [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] lane_sat;
  logic [LANE_LAT-1:0] vld_r;
  logic [LANE_LAT-1:0] sing_r;
  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        out_nxt;

  assign busy = 1'b0;

  mi3_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .in_word    (in_word),
    .f_valid    (f_valid),
    .f_singular (f_singular),
    .f_den      (f_den),
    .f_num      (f_num),
    .f_neg      (f_neg)
  );

  // Nine lanes divide the adjugate entries by the shared determinant
  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk (clk),
      .num (f_num[i]),
      .den (f_den),
      .neg (f_neg[i]),
      .res (lane_res[i]),
      .sat (lane_sat[i])
    );
  end

  // Hold valid and singular alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[LANE_LAT-2:0], f_valid};
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    sing_r <= {sing_r[LANE_LAT-2:0], f_singular};
  end

  // Merge lane results; a singular matrix gives zeros and no saturation
  always_comb begin
    out_nxt.r00       = lane_res[0];
    out_nxt.r01       = lane_res[1];
    out_nxt.r02       = lane_res[2];
    out_nxt.r10       = lane_res[3];
    out_nxt.r11       = lane_res[4];
    out_nxt.r12       = lane_res[5];
    out_nxt.r20       = lane_res[6];
    out_nxt.r21       = lane_res[7];
    out_nxt.r22       = lane_res[8];
    out_nxt.singular  = 1'b0;
    out_nxt.saturated = |lane_sat;
    if (sing_r[LANE_LAT-1]) begin
      out_nxt           = '0;
      out_nxt.singular  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

endmodule

>>> src/mi3_checker.sv
// Port-level checks for the 3x3 matrix inverse, bound to the top level.
module mi3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input mi3_pkg::out_word_t out_word,
  input logic               out_strobe
);
  import mi3_pkg::*;

  // Never refuse a word
  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // Every result traces back to a word taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LATENCY))
    else $error("result without matching input word");

  // Singular results carry zeros and no saturation
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.singular) |->
      (!out_word.saturated && out_word.r00 == '0 && out_word.r01 == '0 &&
       out_word.r02 == '0 && out_word.r10 == '0 && out_word.r11 == '0 &&
       out_word.r12 == '0 && out_word.r20 == '0 && out_word.r21 == '0 &&
       out_word.r22 == '0))
    else $error("singular result not cleared");

endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_word   (out_word),
  .out_strobe (out_strobe)
);

>>> dv/matrix_inverse_3x3_top_tb.sv
// Self-checking bench for the 3x3 fixed-point matrix inverse: driven matrices, predicted inverses.
module matrix_inverse_3x3_top_tb;
  import mi3_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int NUM_MATRICES = 1250;

  typedef logic signed [255:0] wide_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_word_t   in_word;
  logic       out_strobe;
  out_word_t  out_word;

  in_word_t   pending_words[$];
  out_word_t  inverse_queue[$];
  int         error_count;
  int         taken_count;
  int         checked_count;
  int         singular_count;
  int         saturated_count;
  bit         word_taken;
  bit         fill_done;

  matrix_inverse_3x3_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Adjugate over determinant, exact at full width, truncated and clipped per entry
  function automatic out_word_t inverse_of(in_word_t m);
    logic [DW-1:0] f [9];
    wide_t         e [9];
    wide_t         adj [9];
    wide_t         det;
    wide_t         q;
    wide_t         hi_lim;
    wide_t         lo_lim;
    out_word_t     r;
    f = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12, m.m20, m.m21, m.m22};
    r = '0;
    hi_lim = (wide_t'(1) <<< (DW - 1)) - 1;
    lo_lim = -(wide_t'(1) <<< (DW - 1));
    for (int i = 0; i < 9; i++) begin
      e[i] = {{(256 - DW){f[i][DW-1]}}, f[i]};
    end
    for (int i = 0; i < 9; i++) begin
      adj[i] = e[COF_IDX[i][0]] * e[COF_IDX[i][1]] - e[COF_IDX[i][2]] * e[COF_IDX[i][3]];
    end
    det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++) begin
      q = (adj[i] <<< (2 * FRAC_BITS)) / det;
      if (q > hi_lim) begin
        q = hi_lim;
        r.saturated = 1'b1;
      end else if (q < lo_lim) begin
        q = lo_lim;
        r.saturated = 1'b1;
      end
      r[2 + (8 - i) * DW +: DW] = q[DW-1:0];
    end
    return r;
  endfunction

  function automatic in_word_t matrix(int a, int b, int c, int d, int e, int f, int g,
                                      int h, int k);
    in_word_t w;
    w = {a, b, c, d, e, f, g, h, k};
    return w;
  endfunction

  // Pick one entry: full range, modest magnitude, or a corner value
  function automatic int pick_entry(int mode);
    int corner;
    case (mode)
      0: return int'($urandom);
      1: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: begin
        corner = $urandom_range(0, 6);
        case (corner)
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return 0;
          3: return 32'sh0001_0000;
          4: return -32'sh0001_0000;
          5: return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Fill the pending queue: directed corners first, then random matrices
  initial begin
    in_word_t w;
    int       shape;
    int       mode;
    int       v [9];
    int       s;
    fill_done = 1'b0;
    pending_words.push_back(matrix(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000));
    pending_words.push_back(matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(matrix(32'h20000, 0, 0, 0, -32'h40000, 0, 0, 0, 32'h8000));
    pending_words.push_back(matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
    pending_words.push_back(matrix(32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0,
                                   32'h7fffffff));
    pending_words.push_back(matrix(32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0,
                                   32'h80000000));
    pending_words.push_back(matrix(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                   32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                                   32'h80000000));
    pending_words.push_back(matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    pending_words.push_back(matrix(32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000,
                                   32'h60000, 32'h70000, 32'h80000, 32'h90000));
    pending_words.push_back(matrix(32'h10000, 32'h20000, 32'h30000, 0, 32'h10000,
                                   32'h40000, 32'h50000, 32'h60000, 0));
    pending_words.push_back(matrix(0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000));
    pending_words.push_back(matrix(0, 0, -32'h10000, 0, 32'h10000, 0, 32'h10000, 0, 0));
    pending_words.push_back(matrix(32'h100, 0, 0, 0, 32'h100, 0, 0, 0, 32'h100));
    pending_words.push_back(matrix(1, 2, 3, 4, 5, 6, 7, 8, 10));
    pending_words.push_back(matrix(32'h7fffffff, 32'h7fffffff, 0, 32'h80000000,
                                   32'h7fffffff, 0, 0, 0, 1));
    pending_words.push_back(matrix(-32'h10000, 0, 0, 0, -32'h10000, 0, 0, 0, -32'h10000));
    pending_words.push_back(matrix(32'h12345678, -32'h0abcdef0, 32'h0f0f0f0f, 32'h55555555,
                                   -32'h2aaaaaaa, 32'h7ff00000, 32'h00ff00ff, -32'h7f00ff00,
                                   32'h3c3c3c3c));
    pending_words.push_back(matrix(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000));
    while (pending_words.size() < NUM_MATRICES) begin
      shape = $urandom_range(0, 9);
      mode  = (shape < 3) ? 1 : (shape < 6) ? 0 : (shape == 6) ? 2 : $urandom_range(0, 1);
      for (int i = 0; i < 9; i++) v[i] = pick_entry(mode);
      if (shape == 7) begin
        // Make it singular: third row a copy or multiple of the first
        s = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) v[6 + i] = (s == 0) ? v[i] : v[i] * (s == 1 ? 2 : -1);
      end else if (shape == 8) begin
        // Dominant diagonal of random scale
        for (int i = 0; i < 9; i++) if (i % 4 != 0) v[i] = v[i] >>> $urandom_range(4, 20);
      end else if (shape == 9) begin
        // Tiny entries drive the inverse past range
        for (int i = 0; i < 9; i++) v[i] = v[i] >>> $urandom_range(14, 30);
      end
      w = matrix(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
      pending_words.push_back(w);
    end
    fill_done = 1'b1;
  end

  // Record each word the block takes and what it should return
  always @(posedge clk) begin
    word_taken = 1'b0;
    if (rst_n && start && !busy) begin
      word_taken = 1'b1;
      inverse_queue.push_back(inverse_of(in_word));
      taken_count++;
    end
  end

  // Drive words on the falling edge, with random gaps
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n || !fill_done) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_words.size() > 0) begin
      in_word <= pending_words.pop_front();
      start   <= 1'b1;
      // Every few hundred words, run a stretch back to back
      gap_left = ((taken_count / 150) % 3 == 2) ? 0 : gap_length();
    end else begin
      start <= 1'b0;
    end
  end

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_strobe) begin
      if (inverse_queue.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, out_word);
        error_count++;
      end else begin
        want = inverse_queue.pop_front();
        checked_count++;
        if (want.singular) singular_count++;
        if (want.saturated) saturated_count++;
        for (int i = 0; i < 9; i++) begin
          if (out_word[2 + (8 - i) * DW +: DW] !== want[2 + (8 - i) * DW +: DW]) begin
            $display("%0t: r%0d%0d mismatch, expected %h actual %h", $time, i / 3, i % 3,
                     want[2 + (8 - i) * DW +: DW], out_word[2 + (8 - i) * DW +: DW]);
            error_count++;
          end
        end
        if (out_word.singular !== want.singular) begin
          $display("%0t: singular mismatch, expected %b actual %b", $time, want.singular,
                   out_word.singular);
          error_count++;
        end
        if (out_word.saturated !== want.saturated) begin
          $display("%0t: saturated mismatch, expected %b actual %b", $time, want.saturated,
                   out_word.saturated);
          error_count++;
        end
      end
    end
  end

  // Reset, wait for all words to drain, then report
  initial begin
    error_count = 0;
    taken_count = 0;
    checked_count = 0;
    singular_count = 0;
    saturated_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (fill_done);
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (inverse_queue.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (inverse_queue.size() > 0) error_count++;
    $display("Inverted %0d matrices: %0d singular, %0d with clipped entries.",
             checked_count, singular_count, saturated_count);
    $display("Mismatches found: %0d", error_count);
    if (error_count == 0) begin
      $display("matrix_inverse_3x3_top regression: pass");
    end else begin
      $display("matrix_inverse_3x3_top regression: fail");
    end
    $finish;
  end

  // Hard stop if the results never drain
  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding", inverse_queue.size());
    $display("matrix_inverse_3x3_top regression: fail");
    $finish;
  end

endmodule

>>> matrix_inverse_3x3_top.f
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_div_lane.sv
src/matrix_inverse_3x3_top.sv
src/mi3_checker.sv
dv/matrix_inverse_3x3_top_tb.sv
